// ===== design/point_to_oriented_rect_residual_core_assert.svh =====
// Assertion helpers shared by the residual core modules.
// Both expect clk and arst_n in scope.
`ifndef POINT_TO_ORIENTED_RECT_RESIDUAL_CORE_ASSERT_SVH
`define POINT_TO_ORIENTED_RECT_RESIDUAL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRR_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define PRR_ASSERT_NEXT(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define PRR_ASSERT(name, prop)
`define PRR_ASSERT_NEXT(name, cond, expr)
`endif
`endif

// ===== design/prr_pkg.sv =====
package prr_pkg;

	localparam int TRIG_BITS = 16;
	localparam int SIZE_BITS = 15;
	localparam int ERR_BITS  = 18;
	localparam int IDX_BITS  = 3;
	localparam int N_STAGES  = 7;

	// rounding shifts: Q1.14 * mm -> half mm, and Q1.14 * half mm -> mm
	localparam int LOCAL_SHIFT  = 13;
	localparam int GLOBAL_SHIFT = 15;

	localparam logic [IDX_BITS-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_COS_ROT     = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_SIN_ROT     = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_RECT_WIDTH  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_RECT_HEIGHT = 3'd5;

	localparam logic signed [TRIG_BITS-1:0] COS_RESET = 16'sd16384;

	localparam logic signed [ERR_BITS-1:0] ERR_MAX = {1'b0, {(ERR_BITS-1){1'b1}}};
	localparam logic signed [ERR_BITS-1:0] ERR_MIN = {1'b1, {(ERR_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [TRIG_BITS-1:0] cos_rot;
		logic signed [TRIG_BITS-1:0] sin_rot;
		logic [SIZE_BITS-1:0]        rect_width;
		logic [SIZE_BITS-1:0]        rect_height;
	} geom_t;

endpackage

// ===== design/prr_cfg_regs.sv =====
`include "point_to_oriented_rect_residual_core_assert.svh"

module prr_cfg_regs
	import prr_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int CFG_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [IDX_BITS-1:0]          cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_data,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output geom_t                        geom
);

	logic signed [COORD_BITS-1:0] center_x_q;
	logic signed [COORD_BITS-1:0] center_y_q;
	logic signed [TRIG_BITS-1:0]  cos_q;
	logic signed [TRIG_BITS-1:0]  sin_q;
	logic [SIZE_BITS-1:0]         width_q;
	logic [SIZE_BITS-1:0]         height_q;
	logic                         wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			cos_q      <= COS_RESET;
			sin_q      <= '0;
			width_q    <= '0;
			height_q   <= '0;
		end else if (wr) begin
			case (cfg_index)
				REG_CENTER_X:    center_x_q <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Y:    center_y_q <= cfg_data[COORD_BITS-1:0];
				REG_COS_ROT:     cos_q      <= cfg_data[TRIG_BITS-1:0];
				REG_SIN_ROT:     sin_q      <= cfg_data[TRIG_BITS-1:0];
				REG_RECT_WIDTH:  width_q    <= cfg_data[SIZE_BITS-1:0];
				REG_RECT_HEIGHT: height_q   <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign center_x         = center_x_q;
	assign center_y         = center_y_q;
	assign geom.cos_rot     = cos_q;
	assign geom.sin_rot     = sin_q;
	assign geom.rect_width  = width_q;
	assign geom.rect_height = height_q;

	`PRR_ASSERT_NEXT(a_cos_write, wr && cfg_index == REG_COS_ROT,
		cos_q == $past(cfg_data[TRIG_BITS-1:0]))
	`PRR_ASSERT_NEXT(a_width_write, wr && cfg_index == REG_RECT_WIDTH,
		width_q == $past(cfg_data[SIZE_BITS-1:0]))
	`PRR_ASSERT_NEXT(a_no_write_hold, !wr, $stable(cos_q) && $stable(sin_q) && $stable(width_q))

endmodule

// ===== design/prr_fwd_rot.sv =====
module prr_fwd_rot
	import prr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic [2:0]                     en,
	input  logic signed [COORD_BITS-1:0]   point_x,
	input  logic signed [COORD_BITS-1:0]   point_y,
	input  logic signed [COORD_BITS-1:0]   center_x,
	input  logic signed [COORD_BITS-1:0]   center_y,
	input  geom_t                          geom,
	output logic signed [COORD_BITS+4:0]   lx_s3,
	output logic signed [COORD_BITS+4:0]   ly_s3,
	output logic signed [COORD_BITS:0]     dx_s3,
	output logic signed [COORD_BITS:0]     dy_s3
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = DW + TRIG_BITS;
	localparam int SW = PW + 1;

	logic signed [DW-1:0]        dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [PW-1:0]        pcx_s2, psy_s2, pcy_s2, psx_s2;
	logic signed [SW-1:0]        sum_x, sum_y;
	logic signed [TRIG_BITS-1:0] cos_v, sin_v;

	assign cos_v = geom.cos_rot;
	assign sin_v = geom.sin_rot;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= {point_x[COORD_BITS-1], point_x} - {center_x[COORD_BITS-1], center_x};
			dy_s1 <= {point_y[COORD_BITS-1], point_y} - {center_y[COORD_BITS-1], center_y};
		end
		if (en[1]) begin
			pcx_s2 <= cos_v * dx_s1;
			psy_s2 <= sin_v * dy_s1;
			pcy_s2 <= cos_v * dy_s1;
			psx_s2 <= sin_v * dx_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
		end
		if (en[2]) begin
			lx_s3 <= sum_x[SW-1:LOCAL_SHIFT];
			ly_s3 <= sum_y[SW-1:LOCAL_SHIFT];
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
		end
	end

	// add half an LSB, then floor via arithmetic shift
	assign sum_x = {pcx_s2[PW-1], pcx_s2} + {psy_s2[PW-1], psy_s2}
		+ SW'(1 << (LOCAL_SHIFT - 1));
	assign sum_y = {pcy_s2[PW-1], pcy_s2} - {psx_s2[PW-1], psx_s2}
		+ SW'(1 << (LOCAL_SHIFT - 1));

endmodule

// ===== design/prr_edge_sel.sv =====
module prr_edge_sel
	import prr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS+4:0] lx,
	input  logic signed [COORD_BITS+4:0] ly,
	input  logic signed [COORD_BITS:0]   dx,
	input  logic signed [COORD_BITS:0]   dy,
	input  geom_t                        geom,
	output logic signed [15:0]           qx_s4,
	output logic signed [15:0]           qy_s4,
	output logic                         inside_s4,
	output logic signed [COORD_BITS:0]   dx_s4,
	output logic signed [COORD_BITS:0]   dy_s4
);

	localparam int LW = COORD_BITS + 5;
	localparam int XW = (LW > SIZE_BITS + 2) ? LW : SIZE_BITS + 2;

	logic signed [XW-1:0] lx_x, ly_x, w_x, h_x, nw_x, nh_x;
	logic signed [15:0]   w16, h16, nw16, nh16, lx16, ly16, qx_c, qy_c, qx_n, qy_n;
	logic                 lx_lo, lx_hi, ly_lo, ly_hi, in_rect;
	logic [15:0]          d_left, d_right, d_bottom, d_top;

	assign lx_x = XW'(lx);
	assign ly_x = XW'(ly);
	assign w_x  = XW'({1'b0, geom.rect_width});
	assign h_x  = XW'({1'b0, geom.rect_height});
	assign nw_x = -w_x;
	assign nh_x = -h_x;

	assign lx_lo = lx_x < nw_x;
	assign lx_hi = lx_x > w_x;
	assign ly_lo = ly_x < nh_x;
	assign ly_hi = ly_x > h_x;
	assign in_rect = !lx_lo && !lx_hi && !ly_lo && !ly_hi;

	assign w16  = {1'b0, geom.rect_width};
	assign h16  = {1'b0, geom.rect_height};
	assign nw16 = -w16;
	assign nh16 = -h16;
	assign lx16 = lx_x[15:0];
	assign ly16 = ly_x[15:0];

	assign qx_c = lx_lo ? nw16 : (lx_hi ? w16 : lx16);
	assign qy_c = ly_lo ? nh16 : (ly_hi ? h16 : ly16);

	// only meaningful when inside, where they lie in [0, 2*size]
	assign d_left   = lx16 + w16;
	assign d_right  = w16 - lx16;
	assign d_bottom = ly16 + h16;
	assign d_top    = h16 - ly16;

	always_comb begin
		qx_n = qx_c;
		qy_n = qy_c;
		if (in_rect) begin
			if (d_left <= d_right && d_left <= d_bottom && d_left <= d_top)
				qx_n = nw16;
			else if (d_right <= d_bottom && d_right <= d_top)
				qx_n = w16;
			else if (d_bottom <= d_top)
				qy_n = nh16;
			else
				qy_n = h16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s4     <= qx_n;
			qy_s4     <= qy_n;
			inside_s4 <= in_rect;
			dx_s4     <= dx;
			dy_s4     <= dy;
		end
	end

endmodule

// ===== design/prr_back_rot.sv =====
module prr_back_rot
	import prr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic [2:0]                  en,
	input  logic signed [15:0]          qx,
	input  logic signed [15:0]          qy,
	input  logic                        in_rect,
	input  logic signed [COORD_BITS:0]  dx,
	input  logic signed [COORD_BITS:0]  dy,
	input  geom_t                       geom,
	output logic signed [ERR_BITS-1:0]  error_x_s7,
	output logic signed [ERR_BITS-1:0]  error_y_s7,
	output logic                        inside_s7
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 16 + TRIG_BITS;
	localparam int SW = PW + 1;
	localparam int EW = ((DW > ERR_BITS) ? DW : ERR_BITS) + 1;

	logic signed [TRIG_BITS-1:0] cos_v, sin_v;
	logic signed [PW-1:0]        pcx_s5, psy_s5, psx_s5, pcy_s5;
	logic signed [DW-1:0]        dx_s5, dy_s5, dx_s6, dy_s6;
	logic                        inside_s5, inside_s6;
	logic signed [SW-1:0]        sum_x, sum_y;
	logic signed [ERR_BITS-1:0]  gx_s6, gy_s6;
	logic signed [EW-1:0]        diff_x, diff_y;

	assign cos_v = geom.cos_rot;
	assign sin_v = geom.sin_rot;

	assign sum_x = {pcx_s5[PW-1], pcx_s5} - {psy_s5[PW-1], psy_s5}
		+ SW'(1 << (GLOBAL_SHIFT - 1));
	assign sum_y = {psx_s5[PW-1], psx_s5} + {pcy_s5[PW-1], pcy_s5}
		+ SW'(1 << (GLOBAL_SHIFT - 1));

	assign diff_x = EW'(dx_s6) - EW'(gx_s6);
	assign diff_y = EW'(dy_s6) - EW'(gy_s6);

	function automatic logic signed [ERR_BITS-1:0] sat_err(input logic signed [EW-1:0] v);
		logic hi_ones, hi_zeros;
		hi_ones  = &v[EW-1:ERR_BITS-1];
		hi_zeros = ~|v[EW-1:ERR_BITS-1];
		if (hi_ones || hi_zeros)
			sat_err = v[ERR_BITS-1:0];
		else
			sat_err = v[EW-1] ? ERR_MIN : ERR_MAX;
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pcx_s5    <= cos_v * qx;
			psy_s5    <= sin_v * qy;
			psx_s5    <= sin_v * qx;
			pcy_s5    <= cos_v * qy;
			dx_s5     <= dx;
			dy_s5     <= dy;
			inside_s5 <= in_rect;
		end
		if (en[1]) begin
			gx_s6     <= sum_x[SW-1:GLOBAL_SHIFT];
			gy_s6     <= sum_y[SW-1:GLOBAL_SHIFT];
			dx_s6     <= dx_s5;
			dy_s6     <= dy_s5;
			inside_s6 <= inside_s5;
		end
		if (en[2]) begin
			error_x_s7 <= sat_err(diff_x);
			error_y_s7 <= sat_err(diff_y);
			inside_s7  <= inside_s6;
		end
	end

endmodule

// ===== design/point_to_oriented_rect_residual_core.sv =====
// Residual of a 2D point to the boundary of a configured rotated rectangle.
// Input channel: in_valid / in_stall with point_x, point_y (signed mm).
// Output channel: out_valid / out_stall with error_x, error_y (18-bit signed,
// saturated) and was_inside.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Registers: 0 center_x, 1 center_y, 2 cos_rot, 3 sin_rot,
// 4 rect_width, 5 rect_height; other indexes are dropped. Write only when idle.
// An accepted point moves through the stages in order; out_stall can hold it.
// Throughput: one point per cycle unless out_stall backs up a full pipeline.
// Seven register stages: subtract, rotate multiply, round/shift, clamp and
// edge pick, back-rotate multiply, round/shift, subtract and saturate; each
// multiply stage is 16 x (COORD_BITS+1) at most.
// Reset clears all stage valid bits and loads the identity rotation with a
// zero-size rectangle centered at the origin.
// When out_stall is high the held result stays; stages behind it keep filling
// empty slots, and in_stall rises only once all seven stages are full.
`include "point_to_oriented_rect_residual_core_assert.svh"

module point_to_oriented_rect_residual_core
	import prr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ERR_BITS-1:0]   error_x,
	output logic signed [ERR_BITS-1:0]   error_y,
	output logic                         was_inside,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [IDX_BITS-1:0]          cfg_index,
	input  logic [((COORD_BITS > TRIG_BITS) ? COORD_BITS : TRIG_BITS)-1:0] cfg_data
);

	localparam int CFG_BITS = (COORD_BITS > TRIG_BITS) ? COORD_BITS : TRIG_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int LW = COORD_BITS + 5;

	logic signed [COORD_BITS-1:0] center_x, center_y;
	geom_t                        geom;
	logic [N_STAGES:1]            vld_q;
	logic [N_STAGES:1]            en;
	logic signed [LW-1:0]         lx_s3, ly_s3;
	logic signed [DW-1:0]         dx_s3, dy_s3, dx_s4, dy_s4;
	logic signed [15:0]           qx_s4, qy_s4;
	logic                         inside_s4;

	// a stage loads when it is empty or the one ahead of it moves
	assign en[N_STAGES] = !vld_q[N_STAGES] || !out_stall;
	for (genvar i = 1; i < N_STAGES; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= in_valid;
			for (int i = 2; i <= N_STAGES; i++) begin
				if (en[i])
					vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[N_STAGES];

	prr_cfg_regs #(
		.COORD_BITS(COORD_BITS),
		.CFG_BITS(CFG_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.center_x(center_x),
		.center_y(center_y),
		.geom(geom)
	);

	prr_fwd_rot #(.COORD_BITS(COORD_BITS)) u_fwd (
		.clk(clk),
		.en(en[3:1]),
		.point_x(point_x),
		.point_y(point_y),
		.center_x(center_x),
		.center_y(center_y),
		.geom(geom),
		.lx_s3(lx_s3),
		.ly_s3(ly_s3),
		.dx_s3(dx_s3),
		.dy_s3(dy_s3)
	);

	prr_edge_sel #(.COORD_BITS(COORD_BITS)) u_edge (
		.clk(clk),
		.en(en[4]),
		.lx(lx_s3),
		.ly(ly_s3),
		.dx(dx_s3),
		.dy(dy_s3),
		.geom(geom),
		.qx_s4(qx_s4),
		.qy_s4(qy_s4),
		.inside_s4(inside_s4),
		.dx_s4(dx_s4),
		.dy_s4(dy_s4)
	);

	prr_back_rot #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk),
		.en(en[7:5]),
		.qx(qx_s4),
		.qy(qy_s4),
		.in_rect(inside_s4),
		.dx(dx_s4),
		.dy(dy_s4),
		.geom(geom),
		.error_x_s7(error_x),
		.error_y_s7(error_y),
		.inside_s7(was_inside)
	);

	`PRR_ASSERT(a_stall_only_when_full, in_stall |-> (&vld_q) && out_stall)
	`PRR_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld_q[1])
	`PRR_ASSERT_NEXT(a_tail_fills, vld_q[N_STAGES-1] && !vld_q[N_STAGES], vld_q[N_STAGES])
	`PRR_ASSERT(a_edge_on_boundary, vld_q[4] |->
		(qx_s4 == $signed({1'b0, geom.rect_width}) ||
		 qx_s4 == -$signed({1'b0, geom.rect_width}) ||
		 qy_s4 == $signed({1'b0, geom.rect_height}) ||
		 qy_s4 == -$signed({1'b0, geom.rect_height})))

endmodule
